// ----- sv/pfba_pkg.sv -----
package pfba_pkg;

  localparam int PAGE_W  = 16;
  localparam int COUNT_W = 17;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = 17'h1FFFF;
  localparam logic [COUNT_W-1:0] TOTAL_RESET = 17'd65536;

  typedef enum logic [2:0] {
    OP_REQUEST   = 3'd0,
    OP_FREE      = 3'd1,
    OP_LOCK      = 3'd2,
    OP_RESERVE   = 3'd3,
    OP_UNRESERVE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } state_t;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [PAGE_W-1:0] page_index;
  } in_item_t;

  typedef struct packed {
    logic               success;
    logic [PAGE_W-1:0]  granted_page;
    logic [COUNT_W-1:0] free_count;
    logic [COUNT_W-1:0] used_count;
    logic [COUNT_W-1:0] reserved_count;
  } out_item_t;

  // Result of looking at one bitmap word around a page position.
  typedef struct packed {
    logic               in_range;
    logic               found;
    logic               cur_bit;
    logic [COUNT_W-1:0] found_page;
    logic [COUNT_W-1:0] next_pos;
  } eval_t;

endpackage

// ----- sv/pfba_ram.sv -----
module pfba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/pfba_word_eval.sv -----
module pfba_word_eval #(
  parameter int SCAN_WORD_BITS = 32
) (
  input  logic [SCAN_WORD_BITS-1:0]   word,
  input  logic [pfba_pkg::COUNT_W-1:0] pos,
  input  logic [pfba_pkg::COUNT_W-1:0] lim,
  output pfba_pkg::eval_t             ev,
  output logic [SCAN_WORD_BITS-1:0]   found_mask,
  output logic [SCAN_WORD_BITS-1:0]   cur_mask
);

  import pfba_pkg::*;

  localparam int LOG_W = $clog2(SCAN_WORD_BITS);
  localparam int BW    = (LOG_W > 0) ? LOG_W : 1;

  logic [BW-1:0]             off;
  logic [BW-1:0]             first;
  logic [COUNT_W-1:0]        base;
  logic [COUNT_W-1:0]        span;
  logic [SCAN_WORD_BITS-1:0] cand;

  assign off  = BW'(32'(pos) % SCAN_WORD_BITS);
  assign base = pos & ~COUNT_W'(SCAN_WORD_BITS - 1);
  assign span = lim - base;

  // A candidate is a clear bit at or above the start offset and below the limit.
  always_comb begin
    cand  = '0;
    first = '0;
    for (int b = 0; b < SCAN_WORD_BITS; b++) begin
      cand[b] = !word[b] && (BW'(b) >= off) && (COUNT_W'(b) < span);
    end
    for (int b = SCAN_WORD_BITS - 1; b >= 0; b--) begin
      if (cand[b]) begin
        first = BW'(b);
      end
    end
  end

  assign found_mask = SCAN_WORD_BITS'(1) << first;
  assign cur_mask   = SCAN_WORD_BITS'(1) << off;

  assign ev.in_range   = pos < lim;
  assign ev.found      = (pos < lim) && (|cand);
  assign ev.cur_bit    = word[off];
  assign ev.found_page = base + COUNT_W'(first);
  assign ev.next_pos   = base + COUNT_W'(SCAN_WORD_BITS);

endmodule

// ----- sv/page_frame_bitmap_allocator.sv -----
// Page-frame allocator with one taken bit per page held in a word-wide bitmap
// memory, a next-fit search hint and free, used and reserved counts. After
// reset and after every write of total_pages the bitmap goes through a
// clearing pass that zeroes all MAX_PAGES / SCAN_WORD_BITS words (2048 by
// default), during which no transaction is accepted. A free, lock, reserve
// or unreserve reads the bitmap word and then modifies and writes it back.
// A request reads bitmap words from the hint up to the first clear bit, and
// one word more when the scan runs past the page limit. The result sits in
// an output register, so the next transaction may be accepted while the
// previous result waits. SCAN_WORD_BITS must be a power of two that divides
// MAX_PAGES.
module page_frame_bitmap_allocator #(
  parameter int MAX_PAGES      = 65536,
  parameter int SCAN_WORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  pfba_pkg::in_item_t            req_item,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output pfba_pkg::out_item_t           rsp_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pfba_pkg::COUNT_W-1:0]  cfg_data
);

  import pfba_pkg::*;

  localparam int WORDS = MAX_PAGES / SCAN_WORD_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  function automatic logic [COUNT_W-1:0] limit_of(input logic [COUNT_W-1:0] t);
    limit_of = (32'(t) > MAX_PAGES) ? COUNT_W'(MAX_PAGES) : t;
  endfunction

  function automatic logic [AW-1:0] word_of(input logic [COUNT_W-1:0] p);
    word_of = AW'(32'(p) / SCAN_WORD_BITS);
  endfunction

  state_t             state, state_next;
  logic [COUNT_W-1:0] total_pages, total_pages_next;
  logic [COUNT_W-1:0] hint, hint_next;
  logic [COUNT_W-1:0] free_cnt, free_cnt_next;
  logic [COUNT_W-1:0] used_cnt, used_cnt_next;
  logic [COUNT_W-1:0] rsv_cnt, rsv_cnt_next;
  logic [AW-1:0]      clr_addr, clr_addr_next;
  logic [2:0]         op_q, op_q_next;
  logic [COUNT_W-1:0] scan_pos, scan_pos_next;
  logic               rsp_load;
  out_item_t          rsp_item_next;

  logic [COUNT_W-1:0]        lim;
  logic                      rsp_free;
  logic                      ram_we, ram_re;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [SCAN_WORD_BITS-1:0] ram_wdata, ram_rdata;
  eval_t                     ev;
  logic [SCAN_WORD_BITS-1:0] found_mask, cur_mask;
  logic                      ok;
  logic [PAGE_W-1:0]         granted;

  assign lim       = limit_of(total_pages);
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign cfg_ready = 1'b1;

  pfba_ram #(
    .WIDTH (SCAN_WORD_BITS),
    .DEPTH (WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pfba_word_eval #(
    .SCAN_WORD_BITS (SCAN_WORD_BITS)
  ) u_eval (
    .word       (ram_rdata),
    .pos        (scan_pos),
    .lim        (lim),
    .ev         (ev),
    .found_mask (found_mask),
    .cur_mask   (cur_mask)
  );

  always_comb begin
    state_next       = state;
    total_pages_next = total_pages;
    hint_next        = hint;
    free_cnt_next    = free_cnt;
    used_cnt_next    = used_cnt;
    rsv_cnt_next     = rsv_cnt;
    clr_addr_next    = clr_addr;
    op_q_next        = op_q;
    scan_pos_next    = scan_pos;
    req_stall        = 1'b1;
    ram_we           = 1'b0;
    ram_waddr        = word_of(scan_pos);
    ram_wdata        = ram_rdata;
    ram_re           = 1'b0;
    ram_raddr        = word_of(scan_pos);
    rsp_load         = 1'b0;
    ok               = 1'b0;
    granted          = '0;

    unique case (state)
      ST_CLEAR: begin
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        ram_wdata     = '0;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == AW'(WORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          op_q_next  = req_item.opcode;
          if (req_item.opcode == OP_REQUEST) begin
            scan_pos_next = hint;
          end else begin
            scan_pos_next = {1'b0, req_item.page_index};
          end
          ram_re     = 1'b1;
          ram_raddr  = word_of(scan_pos_next);
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        // Everything waits while an earlier result is still held; the read data stays put.
        if (rsp_free) begin
          if (op_q == OP_REQUEST) begin
            if (!ev.in_range) begin
              hint_next  = lim;
              rsp_load   = 1'b1;
              state_next = ST_IDLE;
            end else if (ev.found) begin
              ram_we        = 1'b1;
              ram_wdata     = ram_rdata | found_mask;
              hint_next     = ev.found_page;
              free_cnt_next = (free_cnt == '0) ? '0 : free_cnt - COUNT_W'(1);
              used_cnt_next = (used_cnt < COUNT_MAX) ? used_cnt + COUNT_W'(1) : used_cnt;
              ok            = 1'b1;
              granted       = ev.found_page[PAGE_W-1:0];
              rsp_load      = 1'b1;
              state_next    = ST_IDLE;
            end else begin
              scan_pos_next = ev.next_pos;
              ram_re        = 1'b1;
              ram_raddr     = word_of(ev.next_pos);
            end
          end else begin
            rsp_load   = 1'b1;
            state_next = ST_IDLE;
            unique case (op_q)
              OP_FREE, OP_UNRESERVE: begin
                if (ev.in_range && ev.cur_bit) begin
                  ok        = 1'b1;
                  ram_we    = 1'b1;
                  ram_wdata = ram_rdata & ~cur_mask;
                  if (free_cnt < COUNT_MAX) begin
                    free_cnt_next = free_cnt + COUNT_W'(1);
                  end
                  if (scan_pos < hint) begin
                    hint_next = scan_pos;
                  end
                  if (op_q == OP_FREE) begin
                    used_cnt_next = (used_cnt == '0) ? '0 : used_cnt - COUNT_W'(1);
                  end else begin
                    rsv_cnt_next = (rsv_cnt == '0) ? '0 : rsv_cnt - COUNT_W'(1);
                  end
                end
              end
              OP_LOCK, OP_RESERVE: begin
                if (ev.in_range && !ev.cur_bit) begin
                  ok            = 1'b1;
                  ram_we        = 1'b1;
                  ram_wdata     = ram_rdata | cur_mask;
                  free_cnt_next = (free_cnt == '0) ? '0 : free_cnt - COUNT_W'(1);
                  if (op_q == OP_LOCK) begin
                    if (used_cnt < COUNT_MAX) begin
                      used_cnt_next = used_cnt + COUNT_W'(1);
                    end
                  end else begin
                    if (rsv_cnt < COUNT_MAX) begin
                      rsv_cnt_next = rsv_cnt + COUNT_W'(1);
                    end
                  end
                end
              end
              default: begin
                ok = 1'b0;
              end
            endcase
          end
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase

    // A new page count restarts the allocator with a fresh clearing pass.
    if (cfg_valid) begin
      req_stall        = 1'b1;
      total_pages_next = cfg_data;
      state_next       = ST_CLEAR;
      clr_addr_next    = '0;
      hint_next        = '0;
      free_cnt_next    = limit_of(cfg_data);
      used_cnt_next    = '0;
      rsv_cnt_next     = '0;
    end

    rsp_item_next.success        = ok;
    rsp_item_next.granted_page   = granted;
    rsp_item_next.free_count     = free_cnt_next;
    rsp_item_next.used_count     = used_cnt_next;
    rsp_item_next.reserved_count = rsv_cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      total_pages <= TOTAL_RESET;
      hint        <= '0;
      free_cnt    <= limit_of(TOTAL_RESET);
      used_cnt    <= '0;
      rsv_cnt     <= '0;
      clr_addr    <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      total_pages <= total_pages_next;
      hint        <= hint_next;
      free_cnt    <= free_cnt_next;
      used_cnt    <= used_cnt_next;
      rsv_cnt     <= rsv_cnt_next;
      clr_addr    <= clr_addr_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_q     <= op_q_next;
    scan_pos <= scan_pos_next;
    if (rsp_load) begin
      rsp_item <= rsp_item_next;
    end
  end

  a_hint_bounded: assert property (@(posedge clk) disable iff (rst)
    hint <= lim)
    else $error("search hint above page limit");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> req_stall)
    else $error("transaction accepted during clearing pass");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("bitmap read and write in the same cycle");

  a_result_from_eval: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_EVAL)
    else $error("result raised outside evaluation");

endmodule

// ----- bench/tb_page_frame_bitmap_allocator.sv -----
`timescale 1ns / 1ps

module tb_page_frame_bitmap_allocator;
  import pfba_pkg::*;

  localparam int PAGE_SLOTS    = 65536;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 150;

  localparam logic [COUNT_W-1:0] PAGE_CAP         = 17'd65536;
  localparam logic [2:0]         OP_UNKNOWN_FIRST = 3'd5;
  localparam logic [2:0]         OP_UNKNOWN_LAST  = 3'd7;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  in_item_t           req_item  = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  out_item_t          rsp_item;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_data  = '0;

  bit          burst_mode = 1'b0;
  int unsigned mismatches      = 0;
  int unsigned results_checked = 0;
  int unsigned items_sent      = 0;
  int unsigned settings_used   = 0;

  // Allocator state as the bench expects it to be.
  bit                 taken_map [PAGE_SLOTS];
  logic [COUNT_W-1:0] page_limit;
  logic [COUNT_W-1:0] search_hint;
  logic [COUNT_W-1:0] free_left;
  logic [COUNT_W-1:0] used_total;
  logic [COUNT_W-1:0] reserved_total;
  out_item_t          pending_results [$];

  page_frame_bitmap_allocator i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Timeout with %0d results still pending", pending_results.size());
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    rsp_stall <= !burst_mode && ($urandom_range(0, 99) < 15);
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: expected 0x%0h, got 0x%0h",
                                results_checked, name, want, got));
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending",
                                  results_checked));
      end else begin
        want = pending_results.pop_front();
        check_field("success", 32'(want.success), 32'(rsp_item.success));
        check_field("granted_page", 32'(want.granted_page), 32'(rsp_item.granted_page));
        check_field("free_count", 32'(want.free_count), 32'(rsp_item.free_count));
        check_field("used_count", 32'(want.used_count), 32'(rsp_item.used_count));
        check_field("reserved_count", 32'(want.reserved_count),
                    32'(rsp_item.reserved_count));
      end
    end
  end

  function automatic void reset_allocator(input logic [COUNT_W-1:0] total);
    page_limit = (total > PAGE_CAP) ? PAGE_CAP : total;
    foreach (taken_map[i]) taken_map[i] = 1'b0;
    search_hint    = '0;
    free_left      = page_limit;
    used_total     = '0;
    reserved_total = '0;
  endfunction

  function automatic logic claim_page(input logic [COUNT_W-1:0] page);
    if (taken_map[page]) return 1'b0;
    taken_map[page] = 1'b1;
    if (free_left != 0) free_left--;
    return 1'b1;
  endfunction

  function automatic logic release_page(input logic [COUNT_W-1:0] page);
    if (!taken_map[page]) return 1'b0;
    taken_map[page] = 1'b0;
    if (free_left < COUNT_MAX) free_left++;
    if (page < search_hint) search_hint = page;
    return 1'b1;
  endfunction

  function automatic out_item_t predict_allocation(input in_item_t item);
    out_item_t          res;
    logic [COUNT_W-1:0] pos;
    logic [COUNT_W-1:0] idx;
    logic               flipped;
    res     = '0;
    flipped = 1'b0;
    idx     = {1'b0, item.page_index};
    if (item.opcode == OP_REQUEST) begin
      pos = search_hint;
      while (pos < page_limit && taken_map[pos]) pos++;
      search_hint = pos;
      if (pos < page_limit) begin
        void'(claim_page(pos));
        if (used_total < COUNT_MAX) used_total++;
        flipped          = 1'b1;
        res.granted_page = pos[PAGE_W-1:0];
      end
    end else if (idx < page_limit) begin
      case (item.opcode)
        OP_FREE: begin
          flipped = release_page(idx);
          if (flipped && used_total != 0) used_total--;
        end
        OP_LOCK: begin
          flipped = claim_page(idx);
          if (flipped && used_total < COUNT_MAX) used_total++;
        end
        OP_RESERVE: begin
          flipped = claim_page(idx);
          if (flipped && reserved_total < COUNT_MAX) reserved_total++;
        end
        OP_UNRESERVE: begin
          flipped = release_page(idx);
          if (flipped && reserved_total != 0) reserved_total--;
        end
        default: ;
      endcase
    end
    res.success        = flipped;
    res.free_count     = free_left;
    res.used_count     = used_total;
    res.reserved_count = reserved_total;
    return res;
  endfunction

  // The valid line stays high between back-to-back transactions; it only drops
  // for a random gap or when the caller drains.
  task automatic send_item(input in_item_t item);
    if (!burst_mode && $urandom_range(0, 99) < 15) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_item  <= item;
    do @(posedge clk); while (req_stall);
    pending_results.push_back(predict_allocation(item));
    items_sent++;
  endtask

  task automatic send_op(input logic [2:0] op, input logic [PAGE_W-1:0] page);
    in_item_t item;
    item.opcode     = op;
    item.page_index = page;
    send_item(item);
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    req_valid <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                pending_results.size()));
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_total(input logic [COUNT_W-1:0] total);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= total;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reset_allocator(total);
    settings_used++;
  endtask

  task automatic test_reset_defaults();
    send_op(OP_REQUEST, 16'hFFFF);
    send_op(OP_REQUEST, 16'h0000);
    send_op(OP_LOCK, 16'hFFFF);
    send_op(OP_LOCK, 16'hFFFF);
    send_op(OP_RESERVE, 16'd2);
    send_op(OP_REQUEST, 16'h0000);
    // Freeing page 0 pulls the hint back so the next request reuses it.
    send_op(OP_FREE, 16'd0);
    send_op(OP_REQUEST, 16'h0000);
    send_op(OP_UNRESERVE, 16'd2);
    // Page 3 was taken as used, so the reserved count has to hold at zero.
    send_op(OP_UNRESERVE, 16'd3);
    send_op(OP_FREE, 16'd3);
    send_op(OP_FREE, 16'hFFFF);
    for (int op = OP_UNKNOWN_FIRST; op <= OP_UNKNOWN_LAST; op++) begin
      send_op(op[2:0], 16'h5A5A);
    end
  endtask

  task automatic test_two_page_limit();
    write_total(17'd2);
    // A reserved page released through free leaves the used count at zero.
    send_op(OP_RESERVE, 16'd0);
    send_op(OP_FREE, 16'd0);
    send_op(OP_REQUEST, 16'h0000);
    send_op(OP_REQUEST, 16'h0000);
    send_op(OP_REQUEST, 16'h0000);
    send_op(OP_LOCK, 16'd2);
    send_op(OP_RESERVE, 16'hFFFF);
    send_op(OP_FREE, 16'd1);
    send_op(OP_REQUEST, 16'h0000);
  endtask

  task automatic test_zero_limit();
    write_total(17'd0);
    send_op(OP_REQUEST, 16'h0000);
    send_op(OP_RESERVE, 16'd0);
  endtask

  task automatic run_random_phase(input logic [COUNT_W-1:0] total, input int count);
    in_item_t    item;
    int unsigned pick;
    int unsigned window;
    write_total(total);
    window = (page_limit > 17'd128) ? 32'd128 : 32'(page_limit);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 38)      item.opcode = OP_REQUEST;
      else if (pick < 58) item.opcode = OP_FREE;
      else if (pick < 70) item.opcode = OP_LOCK;
      else if (pick < 82) item.opcode = OP_RESERVE;
      else if (pick < 97) item.opcode = OP_UNRESERVE;
      else item.opcode = 3'($urandom_range(OP_UNKNOWN_FIRST, OP_UNKNOWN_LAST));
      // Mostly hit a low window so frees and locks actually flip bits.
      pick = $urandom_range(0, 99);
      if (window != 0 && pick < 80) begin
        item.page_index = PAGE_W'($urandom_range(0, window - 1));
      end else if (page_limit != 0 && pick < 90) begin
        item.page_index = PAGE_W'($urandom_range(0, 32'(page_limit) - 1));
      end else begin
        item.page_index = PAGE_W'($urandom);
      end
      send_item(item);
      if (n == count / 2) drain_results();
    end
  endtask

  task automatic test_random_traffic();
    logic [COUNT_W-1:0] phase_totals [8];
    phase_totals = '{17'd64, 17'd100, 17'd1, 17'd256, TOTAL_RESET, COUNT_MAX,
                     17'd37, 17'd4096};
    foreach (phase_totals[p]) begin
      burst_mode = (p == 3);
      run_random_phase(phase_totals[p], PHASE_ITEMS);
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    reset_allocator(TOTAL_RESET);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_two_page_limit();
    test_zero_limit();
    test_random_traffic();
    drain_results();
    $display("Sent %0d transactions, checked %0d results across %0d page limits",
             items_sent, results_checked, settings_used + 1);
    $display("Covered requests, frees, locks, reserves, exhaustion and bad indices");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
